@@ sv/http2_frame_deframer_defines.svh @@
// Assertion helpers shared by the deframer RTL
`ifndef HTTP2_FRAME_DEFRAMER_DEFINES_SVH
`define HTTP2_FRAME_DEFRAMER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define H2FD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define H2FD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/h2fd_pkg.sv @@
`default_nettype none

package h2fd_pkg;

	localparam int unsigned PrefaceLen = 24;
	localparam int unsigned HeaderLen  = 9;

	localparam logic [7:0] TYPE_PRIORITY = 8'd2;
	localparam logic [7:0] TYPE_SETTINGS = 8'd4;

	// Result kinds (carried on tuser)
	localparam logic [1:0] KIND_HEADER   = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD  = 2'd1;
	localparam logic [1:0] KIND_MISMATCH = 2'd2;

	// Header check results
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_PROTO = 2'd1;
	localparam logic [1:0] STAT_SIZE  = 2'd2;

	typedef enum logic [3:0] {
		PH_PREFACE = 4'b0001,
		PH_HEADER  = 4'b0010,
		PH_PAYLOAD = 4'b0100,
		PH_DEAD    = 4'b1000
	} phase_t;

	// One result of the parser, before the output register
	typedef struct packed {
		logic        valid;
		logic [1:0]  kind;
		logic [23:0] frame_length;
		logic [7:0]  frame_type;
		logic [7:0]  frame_flags;
		logic [30:0] stream_number;
		logic [1:0]  check_status;
		logic [7:0]  payload_byte;
		logic        frame_last;
	} h2fd_result_t;

	// Client preface "PRI * HTTP/2.0\r\n\r\nSM\r\n\r\n"
	function automatic logic [7:0] preface_byte(input logic [4:0] idx);
		logic [7:0] c;
		unique case (idx)
			5'd0:  c = 8'h50;
			5'd1:  c = 8'h52;
			5'd2:  c = 8'h49;
			5'd3:  c = 8'h20;
			5'd4:  c = 8'h2A;
			5'd5:  c = 8'h20;
			5'd6:  c = 8'h48;
			5'd7:  c = 8'h54;
			5'd8:  c = 8'h54;
			5'd9:  c = 8'h50;
			5'd10: c = 8'h2F;
			5'd11: c = 8'h32;
			5'd12: c = 8'h2E;
			5'd13: c = 8'h30;
			5'd18: c = 8'h53;
			5'd19: c = 8'h4D;
			5'd14, 5'd16, 5'd20, 5'd22: c = 8'h0D;
			5'd15, 5'd17, 5'd21, 5'd23: c = 8'h0A;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// (res * 256 + b) mod 3; 256 = 1 mod 3 and 4 = 1 mod 3, so sum base-4 digits
	function automatic logic [1:0] mod3_step(input logic [1:0] res, input logic [7:0] b);
		logic [3:0] s;
		logic [2:0] t;
		logic [2:0] u;
		s = 4'(res) + 4'(b[1:0]) + 4'(b[3:2]) + 4'(b[5:4]) + 4'(b[7:6]);
		t = 3'(s[3:2]) + 3'(s[1:0]);
		if (t >= 3'd6)
			u = 3'd0;
		else if (t >= 3'd3)
			u = t - 3'd3;
		else
			u = t;
		return u[1:0];
	endfunction

endpackage

`default_nettype wire

@@ sv/h2fd_parser.sv @@
`default_nettype none

module h2fd_parser
	import h2fd_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	input  wire logic [7:0]   in_byte,
	input  wire logic         advance,
	input  wire logic         expect_preface_we,
	input  wire logic         expect_preface_wdata,
	output h2fd_result_t      res
);

	phase_t      phase_q, phase_d;
	logic [4:0]  idx_q, idx_d;
	logic        mism_q, mism_d;
	logic [23:0] len_q, len_d;
	logic [7:0]  type_q, type_d;
	logic [7:0]  flags_q, flags_d;
	logic [30:0] strm_q, strm_d;
	logic [23:0] left_q, left_d;
	logic [1:0]  m3_q, m3_d;
	logic        taken_q;
	logic [1:0]  status;

	// Header checks on the completed header (SETTINGS and PRIORITY only)
	always_comb begin
		status = STAT_OK;
		if (type_d == TYPE_SETTINGS) begin
			if (strm_d != '0)
				status = STAT_PROTO;
			else if (flags_d[0])
				status = (len_d != '0) ? STAT_SIZE : STAT_OK;
			else
				status = (len_d[0] || m3_d != 2'd0) ? STAT_SIZE : STAT_OK;
		end else if (type_d == TYPE_PRIORITY) begin
			if (strm_d == '0)
				status = STAT_PROTO;
			else
				status = (len_d != 24'd5) ? STAT_SIZE : STAT_OK;
		end
	end

	// Next state and result for the byte in the input register
	always_comb begin
		phase_d = phase_q;
		idx_d   = idx_q;
		mism_d  = mism_q;
		len_d   = len_q;
		type_d  = type_q;
		flags_d = flags_q;
		strm_d  = strm_q;
		left_d  = left_q;
		m3_d    = m3_q;
		res     = '0;
		unique case (phase_q)
			PH_PREFACE: begin
				if (in_byte != preface_byte(idx_q))
					mism_d = 1'b1;
				if (idx_q == 5'(PrefaceLen - 1)) begin
					idx_d = '0;
					if (mism_d) begin
						phase_d   = PH_DEAD;
						res.valid = in_valid;
						res.kind  = KIND_MISMATCH;
					end else begin
						phase_d = PH_HEADER;
					end
				end else begin
					idx_d = idx_q + 5'd1;
				end
			end
			PH_HEADER: begin
				if (idx_q < 5'd3) begin
					len_d = {len_q[15:0], in_byte};
					m3_d  = mod3_step((idx_q == 5'd0) ? 2'd0 : m3_q, in_byte);
				end else if (idx_q == 5'd3) begin
					type_d = in_byte;
				end else if (idx_q == 5'd4) begin
					flags_d = in_byte;
				end else if (idx_q == 5'd5) begin
					strm_d = {24'd0, in_byte[6:0]};
				end else begin
					strm_d = {strm_q[22:0], in_byte};
				end
				if (idx_q == 5'(HeaderLen - 1)) begin
					idx_d              = '0;
					res.valid          = in_valid;
					res.kind           = KIND_HEADER;
					res.frame_length   = len_d;
					res.frame_type     = type_d;
					res.frame_flags    = flags_d;
					res.stream_number  = strm_d;
					res.check_status   = status;
					if (len_d == '0) begin
						res.frame_last = 1'b1;
					end else begin
						left_d  = len_d;
						phase_d = PH_PAYLOAD;
					end
				end else begin
					idx_d = idx_q + 5'd1;
				end
			end
			PH_PAYLOAD: begin
				left_d           = left_q - 24'd1;
				res.valid        = in_valid;
				res.kind         = KIND_PAYLOAD;
				res.payload_byte = in_byte;
				if (left_d == '0) begin
					res.frame_last = 1'b1;
					phase_d        = PH_HEADER;
				end
			end
			PH_DEAD: begin
				// drop everything until reset
			end
			default: begin
				phase_d = PH_DEAD;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PREFACE;
			idx_q   <= '0;
			mism_q  <= 1'b0;
			left_q  <= '0;
			taken_q <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
			mism_q  <= mism_d;
			left_q  <= left_d;
			taken_q <= 1'b1;
		end else if (expect_preface_we && !taken_q) begin
			phase_q <= expect_preface_wdata ? PH_PREFACE : PH_HEADER;
		end
	end

	// Header fields being gathered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			type_q  <= '0;
			flags_q <= '0;
			strm_q  <= '0;
			m3_q    <= '0;
		end else if (advance) begin
			len_q   <= len_d;
			type_q  <= type_d;
			flags_q <= flags_d;
			strm_q  <= strm_d;
			m3_q    <= m3_d;
		end
	end

endmodule

`default_nettype wire

@@ sv/http2_frame_deframer.sv @@
// HTTP/2 frame deframer.
// Input stream (s_*): one connection byte per transaction on s_tdata.
// Output stream (m_*): one result per transaction; m_tuser is the kind
// (frame header, payload byte, preface mismatch), m_tlast marks the last
// result of a frame (an empty frame's header included), m_tdata the fields.
// expect_preface_we/_wdata write the preface enable; it selects the start
// phase only if written before the first byte after reset.
// A byte that produces a result passes the input register and then the
// output register, whose valid drives m_tvalid.
// Throughput: one byte per clock unless a result is held back by m_tready;
// the parser state updates once per accepted byte, so bytes follow back to back.
// Reset clears the parser to the preface phase (enable reset value 1) and
// empties both registers, dropping any result still held there.
// When m_tready is low a result waits in the output register; the input
// register still drains bytes that yield no result, and s_tready drops only
// when a result-producing byte has nowhere to go.
// After a preface mismatch one mismatch result is sent and all later bytes
// are accepted and dropped until reset.
`default_nettype none

`include "http2_frame_deframer_defines.svh"

module http2_frame_deframer
	import h2fd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        expect_preface_we,
	input  wire logic        expect_preface_wdata,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] stream_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [87:0]      m_tdata,   // frame_length, frame_type, frame_flags,
	                                    // stream_number, check_status, payload_byte, zero pad
	output logic [1:0]       m_tuser,   // [1:0] kind
	output logic             m_tlast    // frame_last
);

	logic         byte_valid_s1;
	logic [7:0]   byte_s1;
	logic         advance;
	h2fd_result_t res;
	logic         out_valid_q;
	logic [80:0]  out_data_q;
	logic [1:0]   out_kind_q;
	logic         out_last_q;

	h2fd_parser u_parser (
		.clk                  (clk),
		.arst_n               (arst_n),
		.in_valid             (byte_valid_s1),
		.in_byte              (byte_s1),
		.advance              (advance),
		.expect_preface_we    (expect_preface_we),
		.expect_preface_wdata (expect_preface_wdata),
		.res                  (res)
	);

	// Byte in the input register moves on unless its result is blocked
	assign advance  = byte_valid_s1 && (!res.valid || !out_valid_q || m_tready);
	assign s_tready = !byte_valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			byte_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res.valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			out_data_q <= {res.payload_byte, res.check_status, res.stream_number,
				res.frame_flags, res.frame_type, res.frame_length};
			out_kind_q <= res.kind;
			out_last_q <= res.frame_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_data_q};
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

	`H2FD_ASSERT_SAME(a_mismatch_not_last, clk, arst_n,
		m_tvalid && m_tuser == KIND_MISMATCH, !m_tlast, "mismatch result marked last")
	`H2FD_ASSERT_SAME(a_payload_fields_zero, clk, arst_n,
		m_tvalid && m_tuser == KIND_PAYLOAD, m_tdata[72:0] == '0,
		"payload result carries header fields")
	`H2FD_ASSERT_NEXT(a_held_byte_kept, clk, arst_n,
		byte_valid_s1 && !advance, byte_valid_s1 && $stable(byte_s1),
		"stalled input byte lost")

endmodule

`default_nettype wire

@@ test/http2_frame_deframer_tb.sv @@
`timescale 1ns / 100ps

module http2_frame_deframer_tb;
	import h2fd_pkg::*;

	// One result seen at the output, unpacked into its fields
	typedef struct packed {
		logic [1:0]  kind;
		logic [23:0] frame_length;
		logic [7:0]  frame_type;
		logic [7:0]  frame_flags;
		logic [30:0] stream_number;
		logic [1:0]  check_status;
		logic [7:0]  payload_byte;
		logic        frame_last;
	} deframe_res_t;

	// Client preface, first character in the leftmost byte
	localparam logic [0:191] PREFACE_BITS = {"PRI * HTTP/2.0", 8'h0D, 8'h0A, 8'h0D, 8'h0A,
		"SM", 8'h0D, 8'h0A, 8'h0D, 8'h0A};

	logic        clk;
	logic        arst_n = 1'b0;
	logic        expect_preface_we = 1'b0;
	logic        expect_preface_wdata = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [87:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	http2_frame_deframer u_top (
		.clk                  (clk),
		.arst_n               (arst_n),
		.expect_preface_we    (expect_preface_we),
		.expect_preface_wdata (expect_preface_wdata),
		.s_tvalid             (s_tvalid),
		.s_tready             (s_tready),
		.s_tdata              (s_tdata),
		.m_tvalid             (m_tvalid),
		.m_tready             (m_tready),
		.m_tdata              (m_tdata),
		.m_tuser              (m_tuser),
		.m_tlast              (m_tlast)
	);

	// Stimulus and scoreboard storage
	logic [7:0]   tx_bytes[$];
	deframe_res_t pending_results[$];
	int           queued_bytes = 0;
	int           fail_count = 0;
	int           send_idle_pct = 0;
	int           recv_stall_pct = 0;
	logic         hold_go = 1'b0;
	logic         hold_done;
	int           hold_left;

	// Parser shadow state
	phase_t       ph = PH_PREFACE;
	int           byte_idx = 0;
	logic         mism = 1'b0;
	logic         any_taken = 1'b0;
	logic [23:0]  h_len = '0;
	logic [7:0]   h_type = '0;
	logic [7:0]   h_flags = '0;
	logic [30:0]  h_stream = '0;
	logic [23:0]  left = '0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Advance the parser by one accepted byte; returns 1 when a result is due
	function automatic bit parse_byte(input logic [7:0] b, output deframe_res_t r);
		r = '0;
		any_taken = 1'b1;
		case (ph)
			PH_PREFACE: begin
				if (b != PREFACE_BITS[byte_idx*8 +: 8])
					mism = 1'b1;
				byte_idx++;
				if (byte_idx >= PrefaceLen) begin
					byte_idx = 0;
					if (mism) begin
						ph = PH_DEAD;
						r.kind = KIND_MISMATCH;
						return 1'b1;
					end
					ph = PH_HEADER;
				end
				return 1'b0;
			end
			PH_HEADER: begin
				if (byte_idx < 3)
					h_len = {h_len[15:0], b};
				else if (byte_idx == 3)
					h_type = b;
				else if (byte_idx == 4)
					h_flags = b;
				else if (byte_idx == 5)
					h_stream = {24'd0, b[6:0]};
				else
					h_stream = {h_stream[22:0], b};
				byte_idx++;
				if (byte_idx < HeaderLen)
					return 1'b0;
				byte_idx = 0;
				r.kind = KIND_HEADER;
				r.frame_length = h_len;
				r.frame_type = h_type;
				r.frame_flags = h_flags;
				r.stream_number = h_stream;
				// SETTINGS and PRIORITY sanity checks
				if (h_type == TYPE_SETTINGS) begin
					if (h_stream != 0)
						r.check_status = STAT_PROTO;
					else if (h_flags[0])
						r.check_status = (h_len != 0) ? STAT_SIZE : STAT_OK;
					else
						r.check_status = (h_len % 6 != 0) ? STAT_SIZE : STAT_OK;
				end else if (h_type == TYPE_PRIORITY) begin
					if (h_stream == 0)
						r.check_status = STAT_PROTO;
					else
						r.check_status = (h_len != 5) ? STAT_SIZE : STAT_OK;
				end else
					r.check_status = STAT_OK;
				if (h_len == 0)
					r.frame_last = 1'b1;
				else begin
					left = h_len;
					ph = PH_PAYLOAD;
				end
				return 1'b1;
			end
			PH_PAYLOAD: begin
				left = left - 24'd1;
				r.kind = KIND_PAYLOAD;
				r.payload_byte = b;
				if (left == 0) begin
					r.frame_last = 1'b1;
					ph = PH_HEADER;
				end
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	// Sender: offers queued bytes, predicts on each accepted transaction
	always @(posedge clk or negedge arst_n) begin : drive_proc
		deframe_res_t res;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= 8'h00;
		end else begin
			if (s_tvalid && s_tready) begin
				if (parse_byte(s_tdata, res))
					pending_results.push_back(res);
			end
			if (!s_tvalid || s_tready) begin
				if (tx_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata <= tx_bytes.pop_front();
				end else
					s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls plus one long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_go && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= 400;
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else
			m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endtask

	// Output monitor; m_tdata low to high: frame_length, frame_type, frame_flags,
	// stream_number, check_status, payload_byte
	always @(posedge clk) begin : mon_proc
		deframe_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("result transaction with no result expected");
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("kind", 32'(want.kind), 32'(m_tuser));
				check_field("frame_length", 32'(want.frame_length), 32'(m_tdata[23:0]));
				check_field("frame_type", 32'(want.frame_type), 32'(m_tdata[31:24]));
				check_field("frame_flags", 32'(want.frame_flags), 32'(m_tdata[39:32]));
				check_field("stream_number", 32'(want.stream_number),
					32'(m_tdata[70:40]));
				check_field("check_status", 32'(want.check_status), 32'(m_tdata[72:71]));
				check_field("payload_byte", 32'(want.payload_byte), 32'(m_tdata[80:73]));
				check_field("frame_last", 32'(want.frame_last), 32'(m_tlast));
			end
		end
	end

	task automatic push_byte(input logic [7:0] b);
		tx_bytes.push_back(b);
		queued_bytes++;
	endtask

	task automatic push_payload(input int n);
		for (int i = 0; i < n; i++)
			push_byte(8'($urandom));
	endtask

	task automatic add_header(input logic [23:0] len, input logic [7:0] typ,
		input logic [7:0] flags, input logic [31:0] sid);
		push_byte(len[23:16]);
		push_byte(len[15:8]);
		push_byte(len[7:0]);
		push_byte(typ);
		push_byte(flags);
		push_byte(sid[31:24]);
		push_byte(sid[23:16]);
		push_byte(sid[15:8]);
		push_byte(sid[7:0]);
	endtask

	// Random frame, biased toward the checked types and their edge lengths
	task automatic add_random_frame();
		int pick;
		logic [7:0] typ;
		logic [23:0] len;
		logic [31:0] sid;
		pick = $urandom_range(0, 9);
		typ = (pick < 4) ? TYPE_SETTINGS : (pick < 7) ? TYPE_PRIORITY : 8'($urandom);
		sid = $urandom;
		if ($urandom_range(0, 3) == 0)
			sid[30:0] = '0;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			len = 24'd0;
		else if (pick < 4 && typ == TYPE_SETTINGS)
			len = 24'(6 * $urandom_range(0, 3));
		else if (pick < 4 && typ == TYPE_PRIORITY)
			len = 24'd5;
		else if (pick < 9)
			len = 24'($urandom_range(0, 12));
		else
			len = 24'($urandom_range(13, 64));
		add_header(len, typ, 8'($urandom), sid);
		push_payload(int'(len));
	endtask

	// Register write; only issued while the parser is idle
	task automatic cfg_write(input logic v);
		@(posedge clk);
		expect_preface_we <= 1'b1;
		expect_preface_wdata <= v;
		if (!any_taken)
			ph = v ? PH_PREFACE : PH_HEADER;
		@(posedge clk);
		expect_preface_we <= 1'b0;
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (tx_bytes.size() != 0 || s_tvalid || pending_results.size() != 0);
		repeat (6) @(posedge clk);
	endtask

	initial begin : main_proc
		int target;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Start phase picked by the last write before the first byte
		cfg_write(1'b0);
		cfg_write(1'b1);

		// Directed: preface, then headers hitting the OK and protocol-error check outcomes
		for (int i = 0; i < PrefaceLen; i++)
			push_byte(PREFACE_BITS[i*8 +: 8]);
		add_header(24'd0, TYPE_SETTINGS, 8'h01, 32'h0000_0000);
		add_header(24'd5, TYPE_PRIORITY, 8'h00, 32'h8000_0003);
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(8'h80);
		push_byte(8'h7F);
		push_byte(8'h01);
		add_header(24'd7, TYPE_SETTINGS, 8'hFE, 32'h7FFF_FFFF);
		push_payload(7);
		add_header(24'd0, TYPE_PRIORITY, 8'h00, 32'h0000_0000);
		wait_drained();

		// Random phases, each with its own idle pattern and register value
		for (int p = 0; p < 4; p++) begin
			cfg_write(p[0]);
			@(posedge clk);
			case (p)
				0: begin
					send_idle_pct <= 0;
					recv_stall_pct <= 0;
					hold_go <= 1'b1;
				end
				1: begin
					send_idle_pct <= 81;
					recv_stall_pct <= 0;
				end
				2: begin
					send_idle_pct <= 0;
					recv_stall_pct <= 81;
				end
				default: begin
					send_idle_pct <= 37;
					recv_stall_pct <= 37;
				end
			endcase
			target = queued_bytes + 180;
			while (queued_bytes < target)
				add_random_frame();
			if (p == 3) begin
				// Largest length: the payload runs out with the stimulus
				add_header(24'hFF_FFFF, 8'($urandom), 8'($urandom), $urandom);
				push_payload(20);
			end
			wait_drained();
		end

		if (fail_count == 0)
			$display("http2_frame_deframer test passed");
		else
			$display("http2_frame_deframer test failed");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("http2_frame_deframer test failed");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+sv
sv/h2fd_pkg.sv
sv/h2fd_parser.sv
sv/http2_frame_deframer.sv
test/http2_frame_deframer_tb.sv
